/* sv/tccc_pkg.sv */
`default_nettype none

package tccc_pkg;

  // Drawing command codes on the result channel.
  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,
    CMD_DOUBLE = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_t;

  // Main operation of one queued word.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_SINGLE,
    OP_NEWLINE,
    OP_DOUBLE
  } op_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TEXT_COLUMNS = 2'd0,
    REG_TEXT_ROWS    = 2'd1
  } reg_index_t;

  // Character codes with a special meaning.
  localparam logic [7:0] CODE_END     = 8'd0;
  localparam logic [7:0] CODE_BLANK   = 8'd0;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_MARK    = 8'd95;
  localparam logic [7:0] HIGH_CODE    = 8'd128;

  // Reset values of the configuration registers.
  localparam logic [7:0] TEXT_COLUMNS_RESET = 8'd100;
  localparam logic [6:0] TEXT_ROWS_RESET    = 7'd37;

  // One classified byte: an optional flushed lead, a main operation and
  // an optional cursor mark, carried out in that order.
  typedef struct packed {
    logic       flush;
    logic [7:0] flush_code;
    op_t        op;
    logic [7:0] code_a;
    logic [7:0] code_b;
    logic       mark;
  } entry_t;

endpackage

`default_nettype wire

/* sv/tccc_text_if.sv */
`default_nettype none

interface tccc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_string;

  modport source (output valid, text_byte, end_of_string, input ready);
  modport sink (input valid, text_byte, end_of_string, output ready);
endinterface

`default_nettype wire

/* sv/tccc_draw_if.sv */
`default_nettype none

interface tccc_draw_if;
  import tccc_pkg::*;
  logic       valid;
  logic       ready;
  cmd_t       command;
  logic [7:0] first_code;
  logic [7:0] second_code;
  logic [6:0] cell_column;
  logic [5:0] cell_row;
  logic       final_of_run;

  modport source (output valid, command, first_code, second_code, cell_column, cell_row,
                  final_of_run, input ready);
  modport sink (input valid, command, first_code, second_code, cell_column, cell_row,
                final_of_run, output ready);
endinterface

`default_nettype wire

/* sv/tccc_cfg_if.sv */
`default_nettype none

interface tccc_cfg_if;
  import tccc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [7:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/tccc_front.sv */
`default_nettype none

module tccc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  tccc_text_if.sink            text,
  input  wire logic            q_full,
  output logic                 q_push,
  output tccc_pkg::entry_t     q_data
);
  import tccc_pkg::*;

  logic       lead_pending;
  logic [7:0] lead_byte;
  logic       lead_pending_next;
  logic [7:0] lead_byte_next;
  logic       has_work;
  logic       accept;
  op_t        plain_op;

  assign text.ready = !q_full;
  assign accept     = text.valid && !q_full;
  assign q_push     = accept && has_work;

  // Classify the incoming byte against the pending lead byte.
  always_comb begin
    q_data            = '0;
    has_work          = 1'b1;
    lead_pending_next = lead_pending;
    lead_byte_next    = lead_byte;
    plain_op          = (text.text_byte == CODE_NEWLINE) ? OP_NEWLINE : OP_SINGLE;
    q_data.mark       = text.end_of_string;
    priority if (text.text_byte == CODE_END) begin
      q_data.flush      = lead_pending;
      q_data.flush_code = lead_byte;
      q_data.mark       = 1'b1;
      lead_pending_next = 1'b0;
    end else if (lead_pending) begin
      lead_pending_next = 1'b0;
      if (text.text_byte >= HIGH_CODE) begin
        q_data.op     = OP_DOUBLE;
        q_data.code_a = lead_byte;
        q_data.code_b = text.text_byte;
      end else begin
        q_data.flush      = 1'b1;
        q_data.flush_code = lead_byte;
        q_data.op         = plain_op;
        q_data.code_a     = text.text_byte;
      end
    end else if (text.text_byte >= HIGH_CODE) begin
      if (text.end_of_string) begin
        q_data.op     = OP_SINGLE;
        q_data.code_a = text.text_byte;
      end else begin
        // A lead byte is held until the next byte shows whether it has a trail byte.
        has_work          = 1'b0;
        lead_pending_next = 1'b1;
        lead_byte_next    = text.text_byte;
      end
    end else begin
      q_data.op     = plain_op;
      q_data.code_a = text.text_byte;
    end
  end

  // Pending lead state.
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending <= 1'b0;
      lead_byte    <= '0;
    end else if (accept) begin
      lead_pending <= lead_pending_next;
      lead_byte    <= lead_byte_next;
    end
  end

  a_hold_no_push: assert property (@(posedge clk) disable iff (rst)
    accept && !has_work |-> text.text_byte >= HIGH_CODE && !lead_pending)
    else $error("held lead byte on an unexpected path");
  a_hold_sets_pending: assert property (@(posedge clk) disable iff (rst)
    accept && !has_work |=> lead_pending)
    else $error("lead byte was not held");
  a_end_clears_pending: assert property (@(posedge clk) disable iff (rst)
    accept && text.text_byte == CODE_END |=> !lead_pending)
    else $error("end byte left a lead pending");

endmodule

`default_nettype wire

/* sv/tccc_queue.sv */
`default_nettype none

module tccc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tccc_pkg::entry_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output tccc_pkg::entry_t      pop_data,
  output logic                  empty
);
  import tccc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL_COUNT = NW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from an empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("queue count out of range");

endmodule

`default_nettype wire

/* sv/tccc_back.sv */
`default_nettype none

module tccc_back #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       text_columns,
  input  wire logic [6:0]       text_rows,
  input  wire logic             q_empty,
  input  wire tccc_pkg::entry_t q_data,
  output logic                  q_pop,
  tccc_draw_if.source           draw
);
  import tccc_pkg::*;

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [8:0] MAX_C = 9'(MAX_COLUMNS);
  localparam logic [8:0] MAX_R = 9'(MAX_ROWS);

  logic [CW-1:0] cursor_column;
  logic [RW-1:0] cursor_row;
  logic          cur_valid;
  entry_t        cur;
  logic          scroll_pend;
  logic          out_valid;

  logic [8:0] cols9, rows9, cols_eff, rows_eff;
  logic [8:0] cur_col, cur_row, sum1, sum2, row_plus, step_row;
  logic       wrap1, wrap2, step_scroll;
  logic [8:0] col_next, row_next;
  logic       scroll_next;
  entry_t     nxt;
  cmd_t       emit_cmd;
  logic [7:0] emit_a, emit_b;
  logic [8:0] emit_col, emit_row;
  logic       final_cmd, can_emit, fire;

  // Saturated screen size and cursor held inside it.
  always_comb begin
    cols9    = {1'b0, text_columns};
    rows9    = {2'b00, text_rows};
    cols_eff = (cols9 < 9'd2) ? 9'd2 : ((cols9 > MAX_C) ? MAX_C : cols9);
    rows_eff = (rows9 < 9'd1) ? 9'd1 : ((rows9 > MAX_R) ? MAX_R : rows9);
    cur_col  = (9'(cursor_column) >= cols_eff) ? cols_eff - 9'd1 : 9'(cursor_column);
    cur_row  = (9'(cursor_row) >= rows_eff) ? rows_eff - 9'd1 : 9'(cursor_row);
  end

  // Cursor arithmetic for one- and two-cell advances and a row step.
  always_comb begin
    sum1        = cur_col + 9'd1;
    sum2        = cur_col + 9'd2;
    wrap1       = (sum1 >= cols_eff);
    wrap2       = (sum2 >= cols_eff);
    row_plus    = cur_row + 9'd1;
    step_scroll = (row_plus >= rows_eff);
    step_row    = step_scroll ? cur_row : row_plus;
  end

  // Pick the next command of the current word and the state it leaves.
  always_comb begin
    nxt         = cur;
    col_next    = cur_col;
    row_next    = cur_row;
    scroll_next = 1'b0;
    emit_cmd    = CMD_SINGLE;
    emit_a      = CODE_BLANK;
    emit_b      = 8'd0;
    emit_col    = cur_col;
    emit_row    = cur_row;
    priority if (scroll_pend) begin
      emit_cmd = CMD_SCROLL;
      emit_col = 9'd0;
      emit_row = 9'd0;
    end else if (cur.flush || cur.op == OP_SINGLE) begin
      // Single glyph, either a flushed lead or the main byte.
      if (cur.flush) begin
        emit_a    = cur.flush_code;
        nxt.flush = 1'b0;
      end else begin
        emit_a = cur.code_a;
        nxt.op = OP_NONE;
      end
      col_next = wrap1 ? sum1 - cols_eff : sum1;
      if (wrap1) begin
        row_next    = step_row;
        scroll_next = step_scroll;
      end
    end else if (cur.op == OP_NEWLINE || (cur.op == OP_DOUBLE && wrap1)) begin
      // Blank the cell and start a new line; a cut double-byte glyph stays queued.
      if (cur.op == OP_NEWLINE) begin
        nxt.op = OP_NONE;
      end
      col_next    = 9'd0;
      row_next    = step_row;
      scroll_next = step_scroll;
    end else if (cur.op == OP_DOUBLE) begin
      emit_cmd = CMD_DOUBLE;
      emit_a   = cur.code_a;
      emit_b   = cur.code_b;
      nxt.op   = OP_NONE;
      col_next = wrap2 ? sum2 - cols_eff : sum2;
      if (wrap2) begin
        row_next    = step_row;
        scroll_next = step_scroll;
      end
    end else begin
      emit_a   = CODE_MARK;
      nxt.mark = 1'b0;
    end
    final_cmd = !(scroll_next || nxt.flush || nxt.op != OP_NONE || nxt.mark);
  end

  assign can_emit   = !out_valid || draw.ready;
  assign fire       = cur_valid && can_emit;
  assign q_pop      = !q_empty && (!cur_valid || (fire && final_cmd));
  assign draw.valid = out_valid;

  // Control state: cursor, current word and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
      cur_valid     <= 1'b0;
      scroll_pend   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (fire) begin
        cursor_column <= CW'(col_next);
        cursor_row    <= RW'(row_next);
        scroll_pend   <= scroll_next;
        out_valid     <= 1'b1;
      end else if (draw.ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (fire && final_cmd) begin
        cur_valid <= 1'b0;
      end
    end
  end

  // Word and result payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end else if (fire) begin
      cur <= nxt;
    end
    if (fire) begin
      draw.command      <= emit_cmd;
      draw.first_code   <= emit_a;
      draw.second_code  <= emit_b;
      draw.cell_column  <= emit_col[6:0];
      draw.cell_row     <= emit_row[5:0];
      draw.final_of_run <= final_cmd;
    end
  end

  a_word_continues: assert property (@(posedge clk) disable iff (rst)
    fire && !final_cmd |=> cur_valid)
    else $error("word dropped before its last command");
  a_scroll_first: assert property (@(posedge clk) disable iff (rst)
    fire && scroll_pend |-> emit_cmd == CMD_SCROLL)
    else $error("pending scroll not issued first");
  a_scroll_blank: assert property (@(posedge clk) disable iff (rst)
    fire && emit_cmd == CMD_SCROLL |-> emit_a == 8'd0 && emit_b == 8'd0 &&
      emit_col == 9'd0 && emit_row == 9'd0)
    else $error("scroll command carries cell fields");
  a_cell_inside: assert property (@(posedge clk) disable iff (rst)
    fire && emit_cmd != CMD_SCROLL |-> emit_col < cols_eff && emit_row < rows_eff)
    else $error("glyph drawn outside the text area");

endmodule

`default_nettype wire

/* sv/text_console_cursor_controller.sv */
`default_nettype none

// Text console cursor controller.
// The text channel takes one word per cycle while the queue is not full: a
// text byte and an end-of-string flag. The draw channel returns drawing
// commands (single glyph, double-byte glyph, scroll up one row) with the cell
// position, and final_of_run marks the last command a byte caused. The cfg
// channel writes text_columns (index 0) and text_rows (index 1); it is always
// ready and should be used only while no text is in flight.
// A front stage classifies bytes and holds a pending lead byte; a small queue
// of QUEUE_DEPTH words feeds the back stage, which owns the cursor and issues
// one command per cycle while the draw receiver is ready. A byte holds the
// back stage until its last command issues, so a typical printable byte
// sustains one per cycle; one with a flush, wrap, scrolls and a cursor mark
// holds it longer. A held lead byte causes no command. Each byte passes the
// queue, current-word and output registers before reaching the draw channel.
// When the draw receiver stalls, the output register holds its word, the back
// stage waits, and the text channel keeps taking bytes until the queue fills.
// Reset homes the cursor, drops any pending lead, empties the queue and loads
// 100 columns by 37 rows.
module text_console_cursor_controller #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tccc_text_if.sink   text,
  tccc_draw_if.source draw,
  tccc_cfg_if.sink    cfg
);
  import tccc_pkg::*;

  logic [7:0] text_columns;
  logic [6:0] text_rows;
  logic       q_full, q_push, q_pop, q_empty;
  entry_t     q_in, q_out;

  assign cfg.ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_columns <= TEXT_COLUMNS_RESET;
      text_rows    <= TEXT_ROWS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TEXT_COLUMNS: text_columns <= cfg.data;
        REG_TEXT_ROWS:    text_rows    <= cfg.data[6:0];
        default: ;
      endcase
    end
  end

  tccc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  tccc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  tccc_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .text_columns (text_columns),
    .text_rows    (text_rows),
    .q_empty      (q_empty),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .draw         (draw)
  );

endmodule

`default_nettype wire
